### sv/tfiq_pkg.sv
// ============================================================================
// tfiq_pkg: shared types and constants for the triple fault input qualifier
// Channel count, field widths, word layouts, register indexes, reset values.
// ============================================================================
package tfiq_pkg;

  localparam int NUM_CH        = 3;
  localparam int CNT_W         = 8;
  localparam int SHIELD_W      = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_DATA_W     = 8;
  localparam int OUT_DATA_W    = 24;

  // Input word bit positions (lanes take bits 0..NUM_CH-1)
  localparam int IN_MOTOR_BIT  = 3;

  // Output word layout
  localparam int OUT_SHIELD_LO = 3;
  localparam int OUT_USED_W    = NUM_CH + SHIELD_W;

  // Register reset values
  localparam logic [CNT_W-1:0]    HP_SET_RST     = 8'd30;
  localparam logic [CNT_W-1:0]    OFP_SET_RST    = 8'd30;
  localparam logic [CNT_W-1:0]    TP_SET_RST     = 8'd50;
  localparam logic [CNT_W-1:0]    CLEAR_RST      = 8'd50;
  localparam logic [SHIELD_W-1:0] SHIELD_RLD_RST = 16'd100;

  localparam logic [CNT_W-1:0]    CNT_MAX        = {CNT_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HP_SET_LIMIT  = 3'd0,
    REG_OFP_SET_LIMIT = 3'd1,
    REG_TP_SET_LIMIT  = 3'd2,
    REG_CLEAR_LIMIT   = 3'd3,
    REG_SHIELD_RELOAD = 3'd4
  } cfg_reg_t;

  // Per-lane status handed to the merge stage
  typedef struct packed {
    logic fault_nxt;  // fault flag after this tick
    logic hit;        // active and past the set limit this tick
  } lane_stat_t;

endpackage

### sv/triple_fault_input_qualifier_unit.sv
// ============================================================================
// triple_fault_input_qualifier_unit: debounced fault latches with shield timer
// Three parallel channel lanes, a merge stage with the shield countdown.
// ============================================================================
//  channel  dir  ports                     payload
//  in_      in   tvalid/tready/tdata[7:0]  hp_active, ofp_active, tp_active,
//                                          motor_running
//  out_     out  tvalid/tready/tdata[23:0] hp_fault, ofp_fault, tp_fault,
//                                          shield_ticks[15:0]
//  cfg_     in   we/index[2:0]/wdata[15:0] limit and reload registers
//
//  One word in per cycle unless a held result word stalls intake, one result
//  word out per word, registered and shown in the cycle after its word is
//  accepted. Lane counters update on accept. Synchronous active-low reset
//  clears counters, flags, shield and output valid and restores register defaults.
//  A held result word blocks intake only while out_tready is low.
module triple_fault_input_qualifier_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] hp_active, [1] ofp_active, [2] tp_active, [3] motor_running
  input  logic [tfiq_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] hp_fault, [1] ofp_fault, [2] tp_fault, [18:3] shield_ticks
  output logic [tfiq_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [tfiq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfiq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [tfiq_pkg::CNT_W-1:0]    set_limit_r [tfiq_pkg::NUM_CH];
  logic [tfiq_pkg::CNT_W-1:0]    clear_limit_r;
  logic [tfiq_pkg::SHIELD_W-1:0] shield_reload_r;
  tfiq_pkg::lane_stat_t          stat [tfiq_pkg::NUM_CH];
  logic                          tick;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_limit_r[0]  <= tfiq_pkg::HP_SET_RST;
      set_limit_r[1]  <= tfiq_pkg::OFP_SET_RST;
      set_limit_r[2]  <= tfiq_pkg::TP_SET_RST;
      clear_limit_r   <= tfiq_pkg::CLEAR_RST;
      shield_reload_r <= tfiq_pkg::SHIELD_RLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        tfiq_pkg::REG_HP_SET_LIMIT:  set_limit_r[0]  <= cfg_wdata[tfiq_pkg::CNT_W-1:0];
        tfiq_pkg::REG_OFP_SET_LIMIT: set_limit_r[1]  <= cfg_wdata[tfiq_pkg::CNT_W-1:0];
        tfiq_pkg::REG_TP_SET_LIMIT:  set_limit_r[2]  <= cfg_wdata[tfiq_pkg::CNT_W-1:0];
        tfiq_pkg::REG_CLEAR_LIMIT:   clear_limit_r   <= cfg_wdata[tfiq_pkg::CNT_W-1:0];
        tfiq_pkg::REG_SHIELD_RELOAD: shield_reload_r <= cfg_wdata[tfiq_pkg::SHIELD_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick = in_tvalid && in_tready;

  // One lane per fault channel
  for (genvar g = 0; g < tfiq_pkg::NUM_CH; g++) begin : g_lane
    tfiq_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .tick        (tick),
      .active      (in_tdata[g]),
      .set_limit   (set_limit_r[g]),
      .clear_limit (clear_limit_r),
      .stat        (stat[g])
    );
  end

  // Merge, shield countdown and output register
  tfiq_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .motor         (in_tdata[tfiq_pkg::IN_MOTOR_BIT]),
    .stat          (stat),
    .shield_reload (shield_reload_r),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_data      (out_tdata)
  );

endmodule

### sv/tfiq_lane.sv
// ============================================================================
// tfiq_lane: one fault channel debouncer
// Start and cancel counters with hysteresis and a latched fault flag.
// ============================================================================
module tfiq_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick,        // word accepted this cycle
  input  logic                        active,
  input  logic [tfiq_pkg::CNT_W-1:0]  set_limit,
  input  logic [tfiq_pkg::CNT_W-1:0]  clear_limit,
  output tfiq_pkg::lane_stat_t        stat
);

  logic [tfiq_pkg::CNT_W-1:0] start_r, start_nxt;
  logic [tfiq_pkg::CNT_W-1:0] cancel_r, cancel_nxt;
  logic                       fault_r, fault_nxt;
  logic                       start_over;
  logic                       cancel_over;

  assign start_over  = start_r > set_limit;
  assign cancel_over = cancel_r > clear_limit;

  // Counter and flag update for one tick
  always_comb begin
    start_nxt  = start_r;
    cancel_nxt = cancel_r;
    fault_nxt  = fault_r;
    if (active) begin
      cancel_nxt = '0;
      if (start_over) begin
        fault_nxt = 1'b1;
      end else if (start_r != tfiq_pkg::CNT_MAX) begin
        start_nxt = start_r + 1'b1;
      end
    end else if (fault_r) begin
      start_nxt = '0;
      if (cancel_over) begin
        fault_nxt = 1'b0;
      end else if (cancel_r != tfiq_pkg::CNT_MAX) begin
        cancel_nxt = cancel_r + 1'b1;
      end
    end else begin
      start_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      cancel_r <= '0;
      fault_r  <= 1'b0;
    end else if (tick) begin
      start_r  <= start_nxt;
      cancel_r <= cancel_nxt;
      fault_r  <= fault_nxt;
    end
  end

  assign stat.fault_nxt = fault_nxt;
  assign stat.hit       = active & start_over;

endmodule

### sv/tfiq_merge.sv
// ============================================================================
// tfiq_merge: merge stage and output register
// Shield countdown driven by all lanes, result word register, handshake.
// ============================================================================
module tfiq_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              motor,
  input  tfiq_pkg::lane_stat_t              stat [tfiq_pkg::NUM_CH],
  input  logic [tfiq_pkg::SHIELD_W-1:0]     shield_reload,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tfiq_pkg::OUT_DATA_W-1:0]   out_data
);

  logic                              tick;
  logic                              reload;
  logic [tfiq_pkg::NUM_CH-1:0]       hits;
  logic [tfiq_pkg::NUM_CH-1:0]       faults;
  logic [tfiq_pkg::SHIELD_W-1:0]     shield_r, shield_nxt;
  logic                              out_valid_r;
  logic [tfiq_pkg::OUT_DATA_W-1:0]   out_data_r;

  // Output register frees up when empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign tick     = in_valid && in_ready;

  // Gather lane findings
  always_comb begin
    for (int i = 0; i < tfiq_pkg::NUM_CH; i++) begin
      hits[i]   = stat[i].hit;
      faults[i] = stat[i].fault_nxt;
    end
  end

  // Reload overrides the per-tick decrement
  assign reload = motor && (|hits);

  always_comb begin
    if (reload) begin
      shield_nxt = shield_reload;
    end else if (shield_r != '0) begin
      shield_nxt = shield_r - 1'b1;
    end else begin
      shield_nxt = shield_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shield_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (tick) begin
        shield_r <= shield_nxt;
      end
      if (tick) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result word payload
  always_ff @(posedge clk) begin
    if (tick) begin
      out_data_r <= {{(tfiq_pkg::OUT_DATA_W - tfiq_pkg::OUT_USED_W){1'b0}},
                     shield_nxt, faults};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while result word stalled");

  a_shield_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && reload) |=> (shield_r == $past(shield_reload)))
    else $error("shield not reloaded");

  a_shield_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && !reload && shield_r != '0) |=> (shield_r == $past(shield_r) - 1'b1))
    else $error("shield countdown wrong");

  a_shield_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !tick |=> $stable(shield_r))
    else $error("shield moved without a word");

  a_out_matches_shield: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> (out_data_r[tfiq_pkg::OUT_SHIELD_LO +: tfiq_pkg::SHIELD_W] == shield_r))
    else $error("result word shield field out of step");
`endif

endmodule

### verif/triple_fault_input_qualifier_unit_tb.sv
// ============================================================================
// triple_fault_input_qualifier_unit_tb: self-checking bench for the qualifier
// Feeds tick words through the input stream and checks each status word
// against a cycle-free predictor of the debounce counters and shield timer.
// A short directed table comes first. Random phases follow under several
// limit settings, with random idling on both sides and a long receiver stall.
// ============================================================================
module triple_fault_input_qualifier_unit_tb;

  localparam int          HOLD_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef logic [tfiq_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  // Tick word bits
  localparam logic [tfiq_pkg::IN_DATA_W-1:0] HP_ON  = 8'h01;
  localparam logic [tfiq_pkg::IN_DATA_W-1:0] OFP_ON = 8'h02;
  localparam logic [tfiq_pkg::IN_DATA_W-1:0] TP_ON  = 8'h04;
  localparam logic [tfiq_pkg::IN_DATA_W-1:0] RUN_ON = 8'h08;
  localparam logic [tfiq_pkg::IN_DATA_W-1:0] ALL_ON = HP_ON | OFP_ON | TP_ON | RUN_ON;

  typedef struct packed {
    logic [tfiq_pkg::SHIELD_W-1:0] shield;
    logic                          tp;
    logic                          ofp;
    logic                          hp;
  } fault_status_t;

  typedef struct packed {
    logic [tfiq_pkg::IN_DATA_W-1:0] word;
    logic                           typed;  // 1: want below is used as is
    fault_status_t                  want;   // {shield, tp, ofp, hp}
  } drill_row_t;

  // Directed rows; runs under hp/ofp/tp set limits 0/1/2, clear 1, reload max
  localparam int DRILL_N = 20;
  localparam drill_row_t DRILL_TAB [DRILL_N] = '{
    '{8'h00,              1'b1, {16'h0000, 3'b000}},  // state after reset
    '{ALL_ON,             1'b1, {16'h0000, 3'b000}},  // counts start
    '{ALL_ON,             1'b1, {16'hFFFF, 3'b001}},  // hp latches, full reload
    '{ALL_ON,             1'b0, '0},
    '{ALL_ON,             1'b0, '0},
    '{HP_ON|OFP_ON|TP_ON, 1'b0, '0},                   // motor off: no reload
    '{8'h00,              1'b0, '0},
    '{8'h00,              1'b0, '0},
    '{8'h00,              1'b0, '0},                   // faults clear
    '{HP_ON|RUN_ON,       1'b0, '0},
    '{HP_ON|RUN_ON,       1'b0, '0},
    '{OFP_ON,             1'b0, '0},
    '{ALL_ON,             1'b0, '0},
    '{TP_ON|RUN_ON,       1'b0, '0},
    '{TP_ON|RUN_ON,       1'b0, '0},
    '{TP_ON|RUN_ON,       1'b0, '0},
    '{RUN_ON,             1'b0, '0},
    '{8'h00,              1'b0, '0},
    '{8'h00,              1'b0, '0},
    '{8'h00,              1'b0, '0}
  };

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [tfiq_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tfiq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_we     = 1'b0;
  logic [tfiq_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [tfiq_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;

  // Predictor copy of registers and state
  logic [tfiq_pkg::CNT_W-1:0]    set_lim [tfiq_pkg::NUM_CH] =
    '{tfiq_pkg::HP_SET_RST, tfiq_pkg::OFP_SET_RST, tfiq_pkg::TP_SET_RST};
  logic [tfiq_pkg::CNT_W-1:0]    clr_lim          = tfiq_pkg::CLEAR_RST;
  logic [tfiq_pkg::SHIELD_W-1:0] shield_rld       = tfiq_pkg::SHIELD_RLD_RST;
  logic [tfiq_pkg::CNT_W-1:0]    start_cnt  [tfiq_pkg::NUM_CH] = '{default: '0};
  logic [tfiq_pkg::CNT_W-1:0]    cancel_cnt [tfiq_pkg::NUM_CH] = '{default: '0};
  logic                          latched    [tfiq_pkg::NUM_CH] = '{default: 1'b0};
  logic [tfiq_pkg::SHIELD_W-1:0] shield_cnt = '0;

  fault_status_t pending_status [$];

  int          mismatches   = 0;
  int unsigned cycle_cnt    = 0;
  bit          calm         = 1'b0;  // no idling on either side
  int          stall_reqs   = 0;
  int          stall_served = 0;
  int          hold_left    = 0;

  // Random run generator state
  logic        lvl       [tfiq_pkg::NUM_CH] = '{default: 1'b0};
  int unsigned run_left  [tfiq_pkg::NUM_CH] = '{default: 0};
  logic        motor_lvl  = 1'b0;
  int unsigned motor_left = 0;

  always #5 clk = ~clk;

  triple_fault_input_qualifier_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // One tick of the debounce counters and shield timer
  function automatic fault_status_t qualify_tick(
    input logic [tfiq_pkg::IN_DATA_W-1:0] word);
    fault_status_t status;
    if (shield_cnt != '0) shield_cnt = shield_cnt - 1'b1;
    for (int ch = 0; ch < tfiq_pkg::NUM_CH; ch++) begin
      if (word[ch]) begin
        cancel_cnt[ch] = '0;
        if (start_cnt[ch] > set_lim[ch]) begin
          if (word[tfiq_pkg::IN_MOTOR_BIT]) shield_cnt = shield_rld;
          latched[ch] = 1'b1;
        end else if (start_cnt[ch] != tfiq_pkg::CNT_MAX) begin
          start_cnt[ch] = start_cnt[ch] + 1'b1;
        end
      end else if (latched[ch]) begin
        start_cnt[ch] = '0;
        if (cancel_cnt[ch] > clr_lim) latched[ch] = 1'b0;
        else if (cancel_cnt[ch] != tfiq_pkg::CNT_MAX) cancel_cnt[ch] = cancel_cnt[ch] + 1'b1;
      end else begin
        start_cnt[ch] = '0;
      end
    end
    status.hp     = latched[0];
    status.ofp    = latched[1];
    status.tp     = latched[2];
    status.shield = shield_cnt;
    return status;
  endfunction

  // Offer one tick word, maybe after an idle gap; predict on accept
  task automatic send_word(input logic [tfiq_pkg::IN_DATA_W-1:0] word, input logic typed,
                           input fault_status_t want);
    fault_status_t model_out;
    if (!calm && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    model_out = qualify_tick(word);
    pending_status.push_back(typed ? want : model_out);
  endtask

  // Park the input and wait until every status word has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic write_reg(input logic [tfiq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tfiq_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tfiq_pkg::REG_HP_SET_LIMIT:  set_lim[0] = val[tfiq_pkg::CNT_W-1:0];
      tfiq_pkg::REG_OFP_SET_LIMIT: set_lim[1] = val[tfiq_pkg::CNT_W-1:0];
      tfiq_pkg::REG_TP_SET_LIMIT:  set_lim[2] = val[tfiq_pkg::CNT_W-1:0];
      tfiq_pkg::REG_CLEAR_LIMIT:   clr_lim    = val[tfiq_pkg::CNT_W-1:0];
      tfiq_pkg::REG_SHIELD_RELOAD: shield_rld = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // All registers, junk in the upper bits of the 8-bit ones, plus one
  // write to an unused index that must change nothing
  task automatic apply_settings(input logic [tfiq_pkg::CNT_W-1:0] hp,
                                input logic [tfiq_pkg::CNT_W-1:0] ofp,
                                input logic [tfiq_pkg::CNT_W-1:0] tp,
                                input logic [tfiq_pkg::CNT_W-1:0] clr,
                                input logic [tfiq_pkg::SHIELD_W-1:0] rld);
    write_reg(tfiq_pkg::REG_HP_SET_LIMIT,  {8'($urandom), hp});
    write_reg(tfiq_pkg::REG_OFP_SET_LIMIT, {8'($urandom), ofp});
    write_reg(tfiq_pkg::REG_TP_SET_LIMIT,  {8'($urandom), tp});
    write_reg(tfiq_pkg::REG_CLEAR_LIMIT,   {8'($urandom), clr});
    write_reg(tfiq_pkg::REG_SHIELD_RELOAD, rld);
    write_reg(cfg_idx_t'($urandom_range(2**tfiq_pkg::CFG_IDX_W - 1,
                                        int'(tfiq_pkg::REG_SHIELD_RELOAD) + 1)),
              16'($urandom));
  endtask

  // Switch levels held for runs sized around the current limits, so faults
  // latch and clear; noise_pct of the words get one bit flipped
  task automatic run_phase(input int n_items, input int noise_pct);
    logic [tfiq_pkg::IN_DATA_W-1:0] word;
    int unsigned                    span;
    for (int ch = 0; ch < tfiq_pkg::NUM_CH; ch++) run_left[ch] = 0;
    for (int k = 0; k < n_items; k++) begin
      for (int ch = 0; ch < tfiq_pkg::NUM_CH; ch++) begin
        if (run_left[ch] == 0) begin
          lvl[ch]      = ~lvl[ch];
          span         = lvl[ch] ? 32'(set_lim[ch]) : 32'(clr_lim);
          run_left[ch] = $urandom_range(span + span / 2 + 4, 1);
        end
        run_left[ch]--;
      end
      if (motor_left == 0) begin
        motor_lvl  = ~motor_lvl;
        motor_left = $urandom_range(40, 1);
      end
      motor_left--;
      word = '0;
      word[tfiq_pkg::IN_MOTOR_BIT] = motor_lvl;
      for (int ch = 0; ch < tfiq_pkg::NUM_CH; ch++) word[ch] = lvl[ch];
      if ($urandom_range(99) < noise_pct) begin
        word ^= 8'(1 << $urandom_range(tfiq_pkg::IN_MOTOR_BIT));
      end
      send_word(word, 1'b0, '0);
    end
  endtask

  // Receiver: random backpressure, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_served != stall_reqs) begin
      stall_served <= stall_reqs;
      hold_left    <= HOLD_CYCLES;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 15);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Status word checker
  always @(posedge clk) begin
    fault_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_status.size() == 0) begin
        $display("%0t: status word %0h with none expected", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("hp_fault",     32'(want.hp),  32'(out_tdata[0]));
        check_field("ofp_fault",    32'(want.ofp), 32'(out_tdata[1]));
        check_field("tp_fault",     32'(want.tp),  32'(out_tdata[2]));
        check_field("shield_ticks", 32'(want.shield),
                    32'(out_tdata[tfiq_pkg::OUT_SHIELD_LO +: tfiq_pkg::SHIELD_W]));
        check_field("pad bits",     '0,
                    32'(out_tdata[tfiq_pkg::OUT_DATA_W-1:tfiq_pkg::OUT_USED_W]));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    apply_settings(8'd0, 8'd1, 8'd2, 8'd1, 16'hFFFF);
    for (int r = 0; r < DRILL_N; r++) begin
      send_word(DRILL_TAB[r].word, DRILL_TAB[r].typed, DRILL_TAB[r].want);
    end
    drain_results();

    // Default limits
    apply_settings(tfiq_pkg::HP_SET_RST, tfiq_pkg::OFP_SET_RST, tfiq_pkg::TP_SET_RST,
                   tfiq_pkg::CLEAR_RST, tfiq_pkg::SHIELD_RLD_RST);
    run_phase(250, 12);
    drain_results();

    // Zero limits, zero reload
    apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
    run_phase(150, 15);
    drain_results();

    // Small limits, both sides streaming with no idling
    calm = 1'b1;
    apply_settings(8'd3, 8'd7, 8'd12, 8'd5, 16'd9);
    run_phase(250, 10);
    calm = 1'b0;
    drain_results();

    // Top limits: saturating counters, channels that never latch or clear
    apply_settings(tfiq_pkg::CNT_MAX, tfiq_pkg::CNT_MAX - 1'b1, 8'd1, tfiq_pkg::CNT_MAX,
                   16'hFFFF);
    run_phase(400, 0);
    drain_results();

    // Random small limits under a long receiver hold, then a sender pause
    apply_settings(8'($urandom_range(15)), 8'($urandom_range(15)), 8'($urandom_range(15)),
                   8'($urandom_range(15)), 16'($urandom_range(40)));
    stall_reqs <= stall_reqs + 1;
    run_phase(150, 12);
    drain_results();
    run_phase(150, 12);
    drain_results();

    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/tfiq_pkg.sv
sv/tfiq_lane.sv
sv/tfiq_merge.sv
sv/triple_fault_input_qualifier_unit.sv
verif/triple_fault_input_qualifier_unit_tb.sv
